/* rtl/core/cv3_pkg.sv */
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types, widths, register indexes and reset values of the 3x3
// convolution filter.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int PIXEL_W   = 8;
    localparam int COEFF_W   = 8;
    localparam int WIN_DIM   = 3;
    localparam int NUM_TAPS  = WIN_DIM * WIN_DIM;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int COEFF_LO_W   = 64;
    localparam int FRAME_W_W    = 11;
    localparam int FRAME_H_W    = 13;
    localparam int MIN_DIM      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_FIRST_EIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_NINTH        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT       = 2'd3;

    localparam logic [COEFF_LO_W-1:0] RST_COEFFS_FIRST_EIGHT = 64'h0000_0001_0000_0000;
    localparam logic [COEFF_W-1:0]    RST_COEFF_NINTH        = 8'd0;
    localparam logic [FRAME_W_W-1:0]  RST_FRAME_WIDTH        = 11'd1024;
    localparam logic [FRAME_H_W-1:0]  RST_FRAME_HEIGHT       = 13'd768;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [COEFF_W-1:0] t_coeff;

endpackage

/* rtl/core/cv3_ram.sv */
// ----------------------------------------------------------------------------
// cv3_ram
// Generic simple dual-port RAM with one write port and one registered read
// port; the read data holds until the next read.
// ----------------------------------------------------------------------------
module cv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/image_convolution_3x3_core.sv */
// ----------------------------------------------------------------------------
// image_convolution_3x3_core
// 3x3 correlation filter over a raster-order stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one result for every interior
// pixel, marking the last one of each frame with tlast; border pixels give no
// transaction. A result passes stage 1 and the window, product and output
// registers. The two previous rows live in a single 16-bit wide line memory of
// MAX_WIDTH entries with one read and one write port: each pixel reads its
// column, and the shifted column is written back from stage 1 when that stage
// advances, which sets the one-pixel-per-clock rate. The line memory is not
// cleared after reset. The output register is refilled in the cycle it is
// emptied; the input stalls only in reset or while a result waits downstream.
module image_convolution_3x3_core #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cv3_pkg::PIXEL_W-1:0]     s_axis_tdata,   // [7:0] pixel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cv3_pkg::PIXEL_W-1:0]     m_axis_tdata,   // [7:0] filtered
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cv3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = (cv3_pkg::FRAME_W_W > CW + 1) ? cv3_pkg::FRAME_W_W : CW + 1;
    localparam int HCMP = (cv3_pkg::FRAME_H_W > RW + 1) ? cv3_pkg::FRAME_H_W : RW + 1;
    localparam int PW   = cv3_pkg::PIXEL_W;
    localparam int NT   = cv3_pkg::NUM_TAPS;

    // Configuration registers
    logic [cv3_pkg::COEFF_LO_W-1:0] r_coeffs_lo;
    cv3_pkg::t_coeff                r_coeff_ninth;
    logic [cv3_pkg::FRAME_W_W-1:0]  r_frame_width;
    logic [cv3_pkg::FRAME_H_W-1:0]  r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs_lo    <= cv3_pkg::RST_COEFFS_FIRST_EIGHT;
            r_coeff_ninth  <= cv3_pkg::RST_COEFF_NINTH;
            r_frame_width  <= cv3_pkg::RST_FRAME_WIDTH;
            r_frame_height <= cv3_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cv3_pkg::CFG_COEFFS_FIRST_EIGHT: begin
                    r_coeffs_lo <= i_cfg_data[cv3_pkg::COEFF_LO_W-1:0];
                end
                cv3_pkg::CFG_COEFF_NINTH: begin
                    r_coeff_ninth <= i_cfg_data[cv3_pkg::COEFF_W-1:0];
                end
                cv3_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[cv3_pkg::FRAME_W_W-1:0];
                end
                cv3_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[cv3_pkg::FRAME_H_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Last column and last row of the frame, with the size saturated to range
    logic [WCMP-1:0] w_fw_ext;
    logic [HCMP-1:0] w_fh_ext;
    logic [CW-1:0]   w_col_last;
    logic [RW-1:0]   w_row_last;

    assign w_fw_ext = WCMP'(r_frame_width);
    assign w_fh_ext = HCMP'(r_frame_height);

    always_comb begin
        if (w_fw_ext < WCMP'(cv3_pkg::MIN_DIM)) begin
            w_col_last = CW'(cv3_pkg::MIN_DIM - 1);
        end else if (w_fw_ext > WCMP'(MAX_WIDTH)) begin
            w_col_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_col_last = CW'(w_fw_ext - WCMP'(1));
        end
        if (w_fh_ext < HCMP'(cv3_pkg::MIN_DIM)) begin
            w_row_last = RW'(cv3_pkg::MIN_DIM - 1);
        end else if (w_fh_ext > HCMP'(MAX_HEIGHT)) begin
            w_row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            w_row_last = RW'(w_fh_ext - HCMP'(1));
        end
    end

    // Pipeline advance and input acceptance
    logic r_out_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv         = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && w_adv;
    assign s_axis_tready = w_adv;

    // Raster counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col >= w_col_last) begin
            n_col = '0;
            n_row = (r_row >= w_row_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: line memory read in flight
    logic            r_v1;
    logic            r_emit1;
    logic            r_last1;
    cv3_pkg::t_pixel r_px1;
    logic [CW-1:0]   r_col1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px1   <= s_axis_tdata;
            r_col1  <= r_col;
            r_emit1 <= (r_row >= RW'(2)) && (r_col >= CW'(2));
            r_last1 <= (r_row == w_row_last) && (r_col == w_col_last);
        end
    end

    // Line memory: upper row in the high byte, middle row in the low byte
    logic [2*PW-1:0] w_line_rdata;
    logic            w_line_we;
    cv3_pkg::t_pixel w_top;
    cv3_pkg::t_pixel w_mid;

    assign w_top     = w_line_rdata[2*PW-1:PW];
    assign w_mid     = w_line_rdata[PW-1:0];
    assign w_line_we = w_adv && r_v1;

    cv3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_col1),
        .i_wdata ({w_mid, r_px1}),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_line_rdata)
    );

    // Stage 2: window registers
    cv3_pkg::t_pixel r_win [NT];
    logic            r_v2;
    logic            r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            for (int k = 0; k < NT; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_adv) begin
            r_v2 <= r_v1 && r_emit1;
            if (r_v1) begin
                for (int i = 0; i < cv3_pkg::WIN_DIM; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= w_top;
                r_win[5] <= w_mid;
                r_win[8] <= r_px1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last2 <= r_last1;
        end
    end

    // Stage 3: tap products, low byte only
    cv3_pkg::t_coeff w_coeff [NT];
    cv3_pkg::t_pixel r_prod  [NT];
    logic            r_v3;
    logic            r_last3;

    for (genvar k = 0; k < NT; k++) begin : g_tap
        logic [PW+cv3_pkg::COEFF_W-1:0] w_full;
        if (k < NT - 1) begin : g_lo
            assign w_coeff[k] = r_coeffs_lo[k*cv3_pkg::COEFF_W +: cv3_pkg::COEFF_W];
        end else begin : g_hi
            assign w_coeff[k] = r_coeff_ninth;
        end
        assign w_full = r_win[k] * w_coeff[k];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_prod[k] <= w_full[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last3 <= r_last2;
        end
    end

    // Stage 4: sum modulo 256 into the output register
    cv3_pkg::t_pixel w_sum;
    cv3_pkg::t_pixel r_out_data;
    logic            r_out_last;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NT; k++) begin
            w_sum = w_sum + r_prod[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_sum;
            r_out_last <= r_last3;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // The write-back of one column never collides with the read of the next.
    a_no_line_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_line_we && w_accept) |-> (r_col1 != r_col))
        else $error("line memory read and write hit the same column");

    // The frame end always falls on an interior pixel.
    a_last_is_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_last1) |-> r_emit1)
        else $error("frame end marked on a border pixel");

    // A result in the product stage reaches the output register at the next advance.
    a_result_follows_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v3) |=> r_out_valid)
        else $error("result lost between product stage and output");

endmodule
